// ===== rtl/core/svbd_pkg.sv =====
// Package for the slot vote bit deframer: payload structs, event type,
// configuration register indexes and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svbd_pkg;

    // Sizing of the latency saturation and the slot timer
    localparam int LATENCY_BITS      = 16;
    localparam int SLOT_COUNTER_BITS = 32;
    // Compare width wide enough for both the timer and the slot length
    localparam int SLOT_CMP_W = (SLOT_COUNTER_BITS > 32) ? SLOT_COUNTER_BITS : 32;
    localparam logic [15:0] LAT_MAX = (LATENCY_BITS >= 16) ? 16'hFFFF :
                                      16'((32'd1 << LATENCY_BITS) - 32'd1);

    // Event queue between front and back
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_PTR_W = $clog2(EVQ_DEPTH);
    localparam int EVQ_CNT_W = $clog2(EVQ_DEPTH + 1);

    // Reset values of the configuration registers
    localparam logic [31:0] RST_SLOT_LENGTH    = 32'd100000;
    localparam logic [15:0] RST_MISS_THRESHOLD = 16'd200;
    localparam logic [15:0] RST_CHUNK_SIZE     = 16'd1024;
    localparam logic [7:0]  RST_SYNC_PATTERN   = 8'd42;

    // Input action codes
    localparam logic ACT_PROBE = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Configuration register indexes
    typedef enum logic [7:0] {
        CFG_SLOT_LENGTH    = 8'd0,
        CFG_MISS_THRESHOLD = 8'd1,
        CFG_CHUNK_SIZE     = 8'd2,
        CFG_SYNC_PATTERN   = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        action;
        logic [15:0] latency;
        logic [15:0] elapsed;
    } t_in;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [3:0] bits_valid;
    } t_out;

    // One classified event: a decided bit or a flush request
    typedef struct packed {
        logic flush;
        logic bit_val;
    } t_evt;

endpackage
`default_nettype wire

// ===== rtl/core/svbd_evq.sv =====
// Event queue between the slot voting front and the framing back.
// Small register FIFO of svbd_pkg::t_evt entries; depends on svbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svbd_evq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire svbd_pkg::t_evt i_push_evt,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output svbd_pkg::t_evt      o_head
);

    svbd_pkg::t_evt r_mem [svbd_pkg::EVQ_DEPTH];
    logic [svbd_pkg::EVQ_PTR_W-1:0] r_wr_ptr;
    logic [svbd_pkg::EVQ_PTR_W-1:0] r_rd_ptr;
    logic [svbd_pkg::EVQ_CNT_W-1:0] r_count;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == svbd_pkg::EVQ_CNT_W'(svbd_pkg::EVQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store pushed entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_evt;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + svbd_pkg::EVQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + svbd_pkg::EVQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + svbd_pkg::EVQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - svbd_pkg::EVQ_CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/svbd_front.sv =====
// Front end: accepts probe and flush items, keeps the slot timer and the
// hit/miss votes, and pushes decided bits and flushes as events. Uses svbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svbd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire svbd_pkg::t_in  i_in,
    input  wire logic [31:0]    i_slot_length,
    input  wire logic [15:0]    i_miss_threshold,
    input  wire logic           i_q_full,
    output logic                o_push,
    output svbd_pkg::t_evt      o_push_evt
);

    localparam int TW = svbd_pkg::SLOT_COUNTER_BITS;
    localparam int CW = svbd_pkg::SLOT_CMP_W;

    logic [TW-1:0] r_timer;
    logic [31:0]   r_hits;
    logic [31:0]   r_misses;
    logic [TW-1:0] n_timer;
    logic [31:0]   n_hits;
    logic [31:0]   n_misses;

    logic          accept;
    logic [15:0]   lat_sat;
    logic [TW:0]   timer_sum;
    logic [TW-1:0] timer_upd;
    logic          is_miss;
    logic [31:0]   hits_upd;
    logic [31:0]   misses_upd;
    logic          decide;
    logic          vote;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        // Saturate latency and classify the probe
        lat_sat = (i_in.latency > svbd_pkg::LAT_MAX) ? svbd_pkg::LAT_MAX : i_in.latency;
        is_miss = (lat_sat > i_miss_threshold);

        // Advance the slot timer, saturating at full scale
        timer_sum = {1'b0, r_timer} + (TW+1)'(i_in.elapsed);
        timer_upd = timer_sum[TW] ? '1 : timer_sum[TW-1:0];

        // Count the vote, saturating
        hits_upd   = (!is_miss && r_hits != '1) ? r_hits + 32'd1 : r_hits;
        misses_upd = (is_miss && r_misses != '1) ? r_misses + 32'd1 : r_misses;

        decide = (CW'(timer_upd) >= CW'(i_slot_length));
        vote   = (misses_upd >= hits_upd);

        n_timer  = r_timer;
        n_hits   = r_hits;
        n_misses = r_misses;
        o_push   = 1'b0;
        o_push_evt.flush   = 1'b0;
        o_push_evt.bit_val = vote;

        if (accept) begin
            if (i_in.action == svbd_pkg::ACT_FLUSH) begin
                o_push = 1'b1;
                o_push_evt.flush = 1'b1;
            end else if (decide) begin
                o_push   = 1'b1;
                n_timer  = '0;
                n_hits   = '0;
                n_misses = '0;
            end else begin
                n_timer  = timer_upd;
                n_hits   = hits_upd;
                n_misses = misses_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
        end else begin
            r_timer  <= n_timer;
            r_hits   <= n_hits;
            r_misses <= n_misses;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/svbd_back.sv =====
// Back end: takes bit and flush events, runs sync search and chunk framing,
// packs data bits MSB first and holds the output register. Uses svbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svbd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_empty,
    input  wire svbd_pkg::t_evt i_q_head,
    output logic                o_pop,
    input  wire logic [15:0]    i_chunk_size,
    input  wire logic [7:0]     i_sync_pattern,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output svbd_pkg::t_out      o_out
);

    logic        r_data_mode;
    logic [7:0]  r_sync;
    logic [15:0] r_chunk_cnt;
    logic [7:0]  r_acc;
    logic [2:0]  r_bit_cnt;
    logic        r_out_valid;
    svbd_pkg::t_out r_out;

    logic        n_data_mode;
    logic [7:0]  n_sync;
    logic [15:0] n_chunk_cnt;
    logic [7:0]  n_acc;
    logic [2:0]  n_bit_cnt;
    logic        emit;
    svbd_pkg::t_out emit_val;

    logic [7:0]  sync_shifted;
    logic        take_bit;
    logic [15:0] chunk_base;
    logic [15:0] chunk_inc;
    logic [7:0]  acc_set;

    assign o_pop       = !i_q_empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_data_mode = r_data_mode;
        n_sync      = r_sync;
        n_chunk_cnt = r_chunk_cnt;
        n_acc       = r_acc;
        n_bit_cnt   = r_bit_cnt;
        emit        = 1'b0;
        emit_val.byte_value = r_acc;
        emit_val.bits_valid = {1'b0, r_bit_cnt};

        sync_shifted = {r_sync[6:0], i_q_head.bit_val};
        take_bit     = 1'b0;
        chunk_base   = r_chunk_cnt;
        acc_set      = i_q_head.bit_val ? (8'h80 >> r_bit_cnt) : 8'h00;
        chunk_inc    = 16'd0;

        if (o_pop) begin
            if (i_q_head.flush) begin
                // Emit the partial byte if any bits are pending
                if (r_bit_cnt != 3'd0) begin
                    emit      = 1'b1;
                    n_acc     = '0;
                    n_bit_cnt = '0;
                end
            end else if (!r_data_mode) begin
                if (r_sync != i_sync_pattern) begin
                    // Shift the sync register and look for the pattern
                    n_sync = sync_shifted;
                    if (sync_shifted == i_sync_pattern) begin
                        n_data_mode = 1'b1;
                        n_chunk_cnt = '0;
                    end
                end else begin
                    // Pattern already present: this bit is data
                    n_data_mode = 1'b1;
                    chunk_base  = '0;
                    take_bit    = 1'b1;
                end
            end else begin
                take_bit = 1'b1;
            end

            if (take_bit) begin
                // Pack the bit and count it within the chunk
                n_acc     = r_acc | acc_set;
                n_bit_cnt = r_bit_cnt + 3'd1;
                if (r_bit_cnt == 3'd7) begin
                    emit                = 1'b1;
                    emit_val.byte_value = r_acc | acc_set;
                    emit_val.bits_valid = 4'd8;
                    n_acc               = '0;
                    n_bit_cnt           = '0;
                end
                chunk_inc   = chunk_base + 16'd1;
                n_chunk_cnt = chunk_inc;
                if (chunk_inc == i_chunk_size) begin
                    n_data_mode = 1'b0;
                    n_sync      = '0;
                    n_chunk_cnt = '0;
                end
            end
        end
    end

    // Framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_mode <= 1'b0;
            r_sync      <= '0;
            r_chunk_cnt <= '0;
            r_acc       <= '0;
            r_bit_cnt   <= '0;
        end else begin
            r_data_mode <= n_data_mode;
            r_sync      <= n_sync;
            r_chunk_cnt <= n_chunk_cnt;
            r_acc       <= n_acc;
            r_bit_cnt   <= n_bit_cnt;
        end
    end

    // Output register: load on emit, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_val;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/slot_vote_bit_deframer_core.sv =====
// Slot vote bit deframer top level: configuration registers, front end,
// event queue and back end. Depends on svbd_pkg, svbd_front, svbd_evq, svbd_back.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready/i_in) takes probe items (latency and
//   elapsed cycles) and flush items. Output channel (o_out_valid/i_out_ready/
//   o_out) delivers packed data bytes, or a partial byte after a flush.
//   Configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data)
//   is always ready; write it only while the block is idle.
//   Throughput: one item per cycle while the event queue has room. The front
//   end votes and times the slot in the cycle of the transfer; the decided
//   bit or flush is written into a 4-entry event queue, from which the back
//   end pops it, frames it and loads the output register.
//   A stalled receiver holds the output register; the back end stops popping
//   and the front end keeps taking items until the event queue fills, then
//   deasserts o_in_ready.
//   Reset (synchronous, active low) clears slot counters, framing state and
//   the queue, returns to sync mode and restores configuration defaults.
`timescale 1ns / 1ps
`default_nettype none
module slot_vote_bit_deframer_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire svbd_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output svbd_pkg::t_out      o_out,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [7:0]     i_cfg_index,
    input  wire logic [31:0]    i_cfg_data
);

    logic [31:0] r_slot_length;
    logic [15:0] r_miss_threshold;
    logic [15:0] r_chunk_size;
    logic [7:0]  r_sync_pattern;

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    svbd_pkg::t_evt q_push_evt;
    svbd_pkg::t_evt q_head;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_length    <= svbd_pkg::RST_SLOT_LENGTH;
            r_miss_threshold <= svbd_pkg::RST_MISS_THRESHOLD;
            r_chunk_size     <= svbd_pkg::RST_CHUNK_SIZE;
            r_sync_pattern   <= svbd_pkg::RST_SYNC_PATTERN;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                svbd_pkg::CFG_SLOT_LENGTH:    r_slot_length    <= i_cfg_data;
                svbd_pkg::CFG_MISS_THRESHOLD: r_miss_threshold <= i_cfg_data[15:0];
                svbd_pkg::CFG_CHUNK_SIZE:     r_chunk_size     <= i_cfg_data[15:0];
                svbd_pkg::CFG_SYNC_PATTERN:   r_sync_pattern   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    svbd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in             (i_in),
        .i_slot_length    (r_slot_length),
        .i_miss_threshold (r_miss_threshold),
        .i_q_full         (q_full),
        .o_push           (q_push),
        .o_push_evt       (q_push_evt)
    );

    svbd_evq u_evq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_evt (q_push_evt),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    svbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (q_head),
        .o_pop          (q_pop),
        .i_chunk_size   (r_chunk_size),
        .i_sync_pattern (r_sync_pattern),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (o_out)
    );

endmodule
`default_nettype wire
